@@ rtl/core/u8u16_pkg.sv @@
// Package for the UTF-8 to UTF-16 transcoder: field widths, saturation caps,
// code constants and the result record types. No dependencies.
`timescale 1ns / 1ps

package u8u16_pkg;

    // Field widths of the input and result items.
    localparam int BYTE_W  = 8;
    localparam int UNIT_W  = 16;
    localparam int CP_W    = 17;
    localparam int U8_W    = 18;
    localparam int U16_W   = 17;
    localparam int PART_W  = 21;
    localparam int ADD_W   = 3;
    localparam int OUT_DATA_W = 72;
    localparam int OUT_USER_W = 2;

    // Saturation limits, each capped at the largest value of its field.
    localparam int unsigned MAX_BYTES = 65536;
    localparam int unsigned CP_FIELD_MAX = (1 << CP_W) - 1;
    localparam int unsigned U8_FIELD_MAX = (1 << U8_W) - 1;
    localparam int unsigned U16_FIELD_MAX = (1 << U16_W) - 1;
    localparam logic [CP_W-1:0] CP_CAP =
        CP_W'((MAX_BYTES < CP_FIELD_MAX) ? MAX_BYTES : CP_FIELD_MAX);
    localparam logic [U16_W-1:0] U16_CAP =
        U16_W'((MAX_BYTES < U16_FIELD_MAX) ? MAX_BYTES : U16_FIELD_MAX);
    localparam logic [U8_W-1:0] U8_CAP =
        U8_W'(((3 * MAX_BYTES) < U8_FIELD_MAX) ? (3 * MAX_BYTES) : U8_FIELD_MAX);

    // Code constants.
    localparam logic [UNIT_W-1:0] REPLACEMENT  = 16'hFFFD;
    localparam logic [BYTE_W-1:0] TRAIL_LO_DEF = 8'h80;
    localparam logic [BYTE_W-1:0] TRAIL_HI_DEF = 8'hBF;
    localparam logic [BYTE_W-1:0] LEAD2_MIN    = 8'hC2;
    localparam logic [BYTE_W-1:0] LEAD2_MAX    = 8'hDF;
    localparam logic [BYTE_W-1:0] LEAD3_MIN    = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD3_MAX    = 8'hEF;
    localparam logic [BYTE_W-1:0] LEAD4_MIN    = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD4_MAX    = 8'hF4;
    localparam logic [BYTE_W-1:0] LEAD_E0      = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD_ED      = 8'hED;
    localparam logic [BYTE_W-1:0] LEAD_F0      = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD_F4      = 8'hF4;
    localparam logic [BYTE_W-1:0] TRAIL_LO_E0  = 8'hA0;
    localparam logic [BYTE_W-1:0] TRAIL_HI_ED  = 8'h9F;
    localparam logic [BYTE_W-1:0] TRAIL_LO_F0  = 8'h90;
    localparam logic [BYTE_W-1:0] TRAIL_HI_F4  = 8'h8F;
    localparam logic [PART_W-1:0] SUPP_MIN     = 21'h010000;
    localparam logic [PART_W-1:0] SUPP_MAX     = 21'h10FFFF;
    localparam logic [5:0]        HIGH_SURR_TAG = 6'b110110;
    localparam logic [5:0]        LOW_SURR_TAG  = 6'b110111;

    // One UTF-16 unit to be sent, before the running totals are attached.
    typedef struct packed {
        logic [UNIT_W-1:0] unit;
        logic              ends;
        logic              repl;
        logic [ADD_W-1:0]  utf8_add;
    } t_unit;

    // One complete result item as it waits in the output buffer.
    typedef struct packed {
        logic [UNIT_W-1:0] utf16_unit;
        logic              ends_code_point;
        logic              replaced;
        logic [CP_W-1:0]   code_point_count;
        logic [U8_W-1:0]   utf8_end;
        logic [U16_W-1:0]  utf16_end;
        logic              any_invalid;
        logic              run_last;
        logic              string_done;
    } t_result;

    // Saturating add of a small increment to an 18-bit counter.
    function automatic logic [U8_W-1:0] sat_add(input logic [U8_W-1:0] v,
                                                input logic [ADD_W-1:0] add,
                                                input logic [U8_W-1:0] cap);
        logic [U8_W:0] s;
        s = {1'b0, v} + {{(U8_W-ADD_W+1){1'b0}}, add};
        sat_add = (s > {1'b0, cap}) ? cap : s[U8_W-1:0];
    endfunction

endpackage

@@ rtl/core/utf8_to_utf16_transcoder.sv @@
// UTF-8 to UTF-16 transcoder top level: input register, decode logic,
// two-entry result buffer. Depends on u8u16_pkg.
`timescale 1ns / 1ps

// Path: a byte is held in the input register until the result buffer has room
// for its results, which are then written into the buffer; the head entry drives
// the output. Throughput: one byte per cycle while the buffer has room; a byte
// that yields two units (a surrogate pair, or a replacement followed by another
// unit) takes both entries of the buffer, which the single output port drains.
// Reset: synchronous, active low; it clears the handshake state, the pending
// sequence, the running totals and the invalid flag at once.
module utf8_to_utf16_transcoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] byte_value
    input  logic        i_s_axis_tlast,   // end_of_string
    // Result stream.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [15:0] utf16_unit, [32:16] code_point_count, [50:33] utf8_end,
    // [67:51] utf16_end, [68] any_invalid, [69] run_last, [71:70] zero
    output logic [71:0] o_m_axis_tdata,
    // [0] ends_code_point, [1] replaced
    output logic [1:0]  o_m_axis_tuser,
    output logic        o_m_axis_tlast    // string_done
);

    // Input register.
    logic                          r_in_valid;
    logic                          n_in_valid;
    logic [u8u16_pkg::BYTE_W-1:0]  r_in_byte;
    logic                          r_in_eos;

    // Decoder state.
    logic [u8u16_pkg::PART_W-1:0]  r_partial;
    logic [1:0]                    r_trail_left;
    logic [1:0]                    r_prefix_cnt;
    logic [u8u16_pkg::BYTE_W-1:0]  r_trail_lo;
    logic [u8u16_pkg::BYTE_W-1:0]  r_trail_hi;
    logic [u8u16_pkg::U8_W-1:0]    r_u8_total;
    logic [u8u16_pkg::U16_W-1:0]   r_u16_total;
    logic [u8u16_pkg::CP_W-1:0]    r_cp_total;
    logic                          r_invalid;

    logic [u8u16_pkg::PART_W-1:0]  n_partial;
    logic [1:0]                    n_trail_left;
    logic [1:0]                    n_prefix_cnt;
    logic [u8u16_pkg::BYTE_W-1:0]  n_trail_lo;
    logic [u8u16_pkg::BYTE_W-1:0]  n_trail_hi;
    logic [u8u16_pkg::U8_W-1:0]    n_u8_total;
    logic [u8u16_pkg::U16_W-1:0]   n_u16_total;
    logic [u8u16_pkg::CP_W-1:0]    n_cp_total;
    logic                          n_invalid;

    // Result buffer, head in entry 0.
    u8u16_pkg::t_result            r_buf0;
    u8u16_pkg::t_result            r_buf1;
    logic [1:0]                    r_cnt;
    u8u16_pkg::t_result            n_buf0;
    u8u16_pkg::t_result            n_buf1;
    logic [1:0]                    n_cnt;

    // Decode results.
    u8u16_pkg::t_unit              unit0;
    u8u16_pkg::t_unit              unit1;
    logic [1:0]                    res_n;
    u8u16_pkg::t_result            res0;
    u8u16_pkg::t_result            res1;

    logic                          in_fire;
    logic                          pop;
    logic                          proc;
    logic [1:0]                    cnt_after;
    logic [1:0]                    free_slots;

    // Decode one byte against the pending sequence.
    always_comb begin
        u8u16_pkg::t_unit              repl_unit;
        u8u16_pkg::t_unit              ld_unit;
        logic                          ld_n;
        logic                          started;
        logic [1:0]                    ld_tl;
        logic [u8u16_pkg::PART_W-1:0]  ld_part;
        logic [u8u16_pkg::BYTE_W-1:0]  ld_lo;
        logic [u8u16_pkg::BYTE_W-1:0]  ld_hi;
        logic [1:0]                    ld_pc;
        logic                          in_range;
        logic [u8u16_pkg::PART_W-1:0]  cp_cat;
        logic [u8u16_pkg::PART_W-1:0]  cp_off;
        logic [1:0]                    tl_dec;
        logic [u8u16_pkg::ADD_W-1:0]   cnt_inc;

        repl_unit.unit     = u8u16_pkg::REPLACEMENT;
        repl_unit.ends     = 1'b1;
        repl_unit.repl     = 1'b1;
        repl_unit.utf8_add = 3'd3;

        // Lead byte interpretation.
        ld_unit = '0;
        ld_n    = 1'b0;
        started = 1'b0;
        ld_tl   = 2'd0;
        ld_part = '0;
        ld_lo   = u8u16_pkg::TRAIL_LO_DEF;
        ld_hi   = u8u16_pkg::TRAIL_HI_DEF;
        ld_pc   = 2'd0;
        priority if (!r_in_byte[7]) begin
            ld_unit.unit     = {8'h00, r_in_byte};
            ld_unit.ends     = 1'b1;
            ld_unit.repl     = 1'b0;
            ld_unit.utf8_add = 3'd1;
            ld_n             = 1'b1;
        end else if (r_in_byte >= u8u16_pkg::LEAD2_MIN &&
                     r_in_byte <= u8u16_pkg::LEAD2_MAX) begin
            started = 1'b1;
            ld_tl   = 2'd1;
            ld_part = {16'h0000, r_in_byte[4:0]};
        end else if (r_in_byte >= u8u16_pkg::LEAD3_MIN &&
                     r_in_byte <= u8u16_pkg::LEAD3_MAX) begin
            started = 1'b1;
            ld_tl   = 2'd2;
            ld_part = {17'h00000, r_in_byte[3:0]};
            if (r_in_byte == u8u16_pkg::LEAD_E0) begin
                ld_lo = u8u16_pkg::TRAIL_LO_E0;
            end else if (r_in_byte == u8u16_pkg::LEAD_ED) begin
                ld_hi = u8u16_pkg::TRAIL_HI_ED;
            end
        end else if (r_in_byte >= u8u16_pkg::LEAD4_MIN &&
                     r_in_byte <= u8u16_pkg::LEAD4_MAX) begin
            started = 1'b1;
            ld_tl   = 2'd3;
            ld_part = {18'h00000, r_in_byte[2:0]};
            if (r_in_byte == u8u16_pkg::LEAD_F0) begin
                ld_lo = u8u16_pkg::TRAIL_LO_F0;
            end else if (r_in_byte == u8u16_pkg::LEAD_F4) begin
                ld_hi = u8u16_pkg::TRAIL_HI_F4;
            end
        end else begin
            ld_unit = repl_unit;
            ld_n    = 1'b1;
        end
        if (started) begin
            ld_pc = 2'd1;
            // A string that ends right after a lead byte is a truncated tail.
            if (r_in_eos) begin
                ld_unit = repl_unit;
                ld_n    = 1'b1;
                ld_tl   = 2'd0;
                ld_part = '0;
                ld_lo   = u8u16_pkg::TRAIL_LO_DEF;
                ld_hi   = u8u16_pkg::TRAIL_HI_DEF;
                ld_pc   = 2'd0;
            end
        end

        // Trail byte interpretation.
        in_range = (r_in_byte >= r_trail_lo) && (r_in_byte <= r_trail_hi);
        cp_cat   = {r_partial[u8u16_pkg::PART_W-7:0], r_in_byte[5:0]};
        cp_off   = cp_cat - u8u16_pkg::SUPP_MIN;
        tl_dec   = r_trail_left - 2'd1;
        cnt_inc  = {1'b0, r_prefix_cnt} + 3'd1;

        unit0        = '0;
        unit1        = '0;
        res_n        = 2'd0;
        n_trail_left = 2'd0;
        n_partial    = '0;
        n_trail_lo   = u8u16_pkg::TRAIL_LO_DEF;
        n_trail_hi   = u8u16_pkg::TRAIL_HI_DEF;
        n_prefix_cnt = 2'd0;

        if (r_trail_left != 2'd0 && in_range) begin
            if (tl_dec == 2'd0) begin
                // Sequence complete: one unit, or a surrogate pair above FFFF.
                if (cp_cat >= u8u16_pkg::SUPP_MIN && cp_cat <= u8u16_pkg::SUPP_MAX) begin
                    unit0.unit     = {u8u16_pkg::HIGH_SURR_TAG, cp_off[19:10]};
                    unit0.ends     = 1'b0;
                    unit0.repl     = 1'b0;
                    unit0.utf8_add = 3'd0;
                    unit1.unit     = {u8u16_pkg::LOW_SURR_TAG, cp_off[9:0]};
                    unit1.ends     = 1'b1;
                    unit1.repl     = 1'b0;
                    unit1.utf8_add = cnt_inc;
                    res_n          = 2'd2;
                end else begin
                    unit0.unit     = cp_cat[u8u16_pkg::UNIT_W-1:0];
                    unit0.ends     = 1'b1;
                    unit0.repl     = 1'b0;
                    unit0.utf8_add = cnt_inc;
                    res_n          = 2'd1;
                end
            end else if (r_in_eos) begin
                unit0 = repl_unit;
                res_n = 2'd1;
            end else begin
                n_trail_left = tl_dec;
                n_partial    = cp_cat;
                n_prefix_cnt = cnt_inc[1:0];
            end
        end else if (r_trail_left != 2'd0) begin
            // Bad trail byte: replace the prefix, then treat the byte as a lead.
            unit0        = repl_unit;
            unit1        = ld_unit;
            res_n        = ld_n ? 2'd2 : 2'd1;
            n_trail_left = ld_tl;
            n_partial    = ld_part;
            n_trail_lo   = ld_lo;
            n_trail_hi   = ld_hi;
            n_prefix_cnt = ld_pc;
        end else begin
            unit0        = ld_unit;
            res_n        = {1'b0, ld_n};
            n_trail_left = ld_tl;
            n_partial    = ld_part;
            n_trail_lo   = ld_lo;
            n_trail_hi   = ld_hi;
            n_prefix_cnt = ld_pc;
        end
    end

    // Running totals after each unit and the result records.
    always_comb begin
        logic [u8u16_pkg::U16_W-1:0] u16_a;
        logic [u8u16_pkg::CP_W-1:0]  cp_a;
        logic [u8u16_pkg::U8_W-1:0]  u8_a;
        logic                        inv_a;
        logic [u8u16_pkg::U16_W-1:0] u16_b;
        logic [u8u16_pkg::CP_W-1:0]  cp_b;
        logic [u8u16_pkg::U8_W-1:0]  u8_b;
        logic                        inv_b;

        u16_a = u8u16_pkg::U16_W'(u8u16_pkg::sat_add({1'b0, r_u16_total}, 3'd1,
                                                     {1'b0, u8u16_pkg::U16_CAP}));
        cp_a  = unit0.ends ?
                u8u16_pkg::CP_W'(u8u16_pkg::sat_add({1'b0, r_cp_total}, 3'd1,
                                                    {1'b0, u8u16_pkg::CP_CAP})) :
                r_cp_total;
        u8_a  = unit0.ends ?
                u8u16_pkg::sat_add(r_u8_total, unit0.utf8_add, u8u16_pkg::U8_CAP) :
                r_u8_total;
        inv_a = r_invalid | unit0.repl;

        u16_b = u8u16_pkg::U16_W'(u8u16_pkg::sat_add({1'b0, u16_a}, 3'd1,
                                                     {1'b0, u8u16_pkg::U16_CAP}));
        cp_b  = unit1.ends ?
                u8u16_pkg::CP_W'(u8u16_pkg::sat_add({1'b0, cp_a}, 3'd1,
                                                    {1'b0, u8u16_pkg::CP_CAP})) :
                cp_a;
        u8_b  = unit1.ends ?
                u8u16_pkg::sat_add(u8_a, unit1.utf8_add, u8u16_pkg::U8_CAP) :
                u8_a;
        inv_b = inv_a | unit1.repl;

        res0.utf16_unit       = unit0.unit;
        res0.ends_code_point  = unit0.ends;
        res0.replaced         = unit0.repl;
        res0.code_point_count = cp_a;
        res0.utf8_end         = u8_a;
        res0.utf16_end        = u16_a;
        res0.any_invalid      = inv_a;
        res0.run_last         = (res_n == 2'd1);
        res0.string_done      = (res_n == 2'd1) && r_in_eos;

        res1.utf16_unit       = unit1.unit;
        res1.ends_code_point  = unit1.ends;
        res1.replaced         = unit1.repl;
        res1.code_point_count = cp_b;
        res1.utf8_end         = u8_b;
        res1.utf16_end        = u16_b;
        res1.any_invalid      = inv_b;
        res1.run_last         = 1'b1;
        res1.string_done      = r_in_eos;

        // The end of a string returns every total to zero.
        if (r_in_eos) begin
            n_u16_total = '0;
            n_cp_total  = '0;
            n_u8_total  = '0;
            n_invalid   = 1'b0;
        end else if (res_n == 2'd2) begin
            n_u16_total = u16_b;
            n_cp_total  = cp_b;
            n_u8_total  = u8_b;
            n_invalid   = inv_b;
        end else if (res_n == 2'd1) begin
            n_u16_total = u16_a;
            n_cp_total  = cp_a;
            n_u8_total  = u8_a;
            n_invalid   = inv_a;
        end else begin
            n_u16_total = r_u16_total;
            n_cp_total  = r_cp_total;
            n_u8_total  = r_u8_total;
            n_invalid   = r_invalid;
        end
    end

    // Handshake and result buffer control.
    always_comb begin
        pop        = (r_cnt != 2'd0) && i_m_axis_tready;
        cnt_after  = r_cnt - {1'b0, pop};
        free_slots = 2'd2 - cnt_after;
        proc       = r_in_valid && (res_n <= free_slots);
        in_fire    = i_s_axis_tvalid && o_s_axis_tready;
        n_in_valid = in_fire ? 1'b1 : (proc ? 1'b0 : r_in_valid);

        n_buf0 = pop ? r_buf1 : r_buf0;
        n_buf1 = r_buf1;
        if (proc) begin
            unique case (cnt_after)
                2'd0: begin
                    if (res_n != 2'd0) begin
                        n_buf0 = res0;
                    end
                    if (res_n == 2'd2) begin
                        n_buf1 = res1;
                    end
                end
                2'd1: begin
                    if (res_n != 2'd0) begin
                        n_buf1 = res0;
                    end
                end
                default: begin
                end
            endcase
        end
        n_cnt = proc ? (cnt_after + res_n) : cnt_after;
    end

    assign o_s_axis_tready = !r_in_valid || proc;
    assign o_m_axis_tvalid = (r_cnt != 2'd0);
    assign o_m_axis_tdata  = {2'b00, r_buf0.run_last, r_buf0.any_invalid,
                              r_buf0.utf16_end, r_buf0.utf8_end,
                              r_buf0.code_point_count, r_buf0.utf16_unit};
    assign o_m_axis_tuser  = {r_buf0.replaced, r_buf0.ends_code_point};
    assign o_m_axis_tlast  = r_buf0.string_done;

    // Control and decoder state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_cnt        <= 2'd0;
            r_partial    <= '0;
            r_trail_left <= 2'd0;
            r_prefix_cnt <= 2'd0;
            r_trail_lo   <= u8u16_pkg::TRAIL_LO_DEF;
            r_trail_hi   <= u8u16_pkg::TRAIL_HI_DEF;
            r_u8_total   <= '0;
            r_u16_total  <= '0;
            r_cp_total   <= '0;
            r_invalid    <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
            r_cnt      <= n_cnt;
            if (proc) begin
                r_partial    <= n_partial;
                r_trail_left <= n_trail_left;
                r_prefix_cnt <= n_prefix_cnt;
                r_trail_lo   <= n_trail_lo;
                r_trail_hi   <= n_trail_hi;
                r_u8_total   <= n_u8_total;
                r_u16_total  <= n_u16_total;
                r_cp_total   <= n_cp_total;
                r_invalid    <= n_invalid;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_eos  <= i_s_axis_tlast;
        end
        r_buf0 <= n_buf0;
        r_buf1 <= n_buf1;
    end

`ifndef ASSERT_OFF
    // The result buffer never holds more than two entries.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2)
        else $error("result buffer overfilled");

    // The final byte of a string always yields at least one result.
    a_eos_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && r_in_eos) |-> (res_n != 2'd0))
        else $error("end of string produced no result");

    // After the final byte every total and the pending sequence are cleared.
    a_eos_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && r_in_eos) |=> (r_trail_left == 2'd0 && r_u16_total == '0 &&
                                r_cp_total == '0 && r_u8_total == '0 && !r_invalid))
        else $error("state not cleared after end of string");

    // With no sequence pending the trail window is the default one.
    a_window_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_trail_left == 2'd0) |-> (r_trail_lo == u8u16_pkg::TRAIL_LO_DEF &&
                                    r_trail_hi == u8u16_pkg::TRAIL_HI_DEF))
        else $error("trail window left narrowed while idle");

    // A replacement unit always carries the invalid flag.
    a_repl_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && r_buf0.replaced) |-> r_buf0.any_invalid)
        else $error("replacement without invalid flag");
`endif

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for utf8_to_utf16_transcoder: a directed byte table,
// then random UTF-8 strings with noise, checked against a predictor or against
// the result a typed table row carries. Depends on u8u16_pkg and the transcoder RTL.
`timescale 1ns / 1ps

module tb;

    // One row of the directed table; typed rows carry their single result.
    typedef struct {
        logic [7:0]         byte_value;
        logic               eos;
        logic               typed;
        u8u16_pkg::t_result want;
    } t_byte_row;

    localparam u8u16_pkg::t_result NO_WANT = '0;
    localparam int DIR_ROWS = 27;
    localparam int RANDOM_ITEMS = 500;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 20;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_data;
    logic        s_last;
    logic        m_valid;
    logic        m_ready;
    logic [71:0] m_data;
    logic [1:0]  m_user;
    logic        m_last;

    // Side information for the request being offered.
    logic               row_typed;
    u8u16_pkg::t_result row_want;

    // Predictor state.
    logic [20:0] cp_acc;
    logic [1:0]  trails_due;
    logic [1:0]  seq_len;
    logic [7:0]  trail_lo;
    logic [7:0]  trail_hi;
    int unsigned u8_sum;
    int unsigned u16_sum;
    int unsigned cp_sum;
    logic        bad_seen;

    u8u16_pkg::t_result step_units[$];
    u8u16_pkg::t_result units_due[$];
    logic [7:0]         str_bytes[$];

    int          fail_count;
    int          items_sent;
    int          burst_left;
    int          steady_left;
    bit          hold_pending;

    t_byte_row dir_table [0:DIR_ROWS-1] = '{
        '{8'h00, 1'b0, 1'b1,
          '{16'h0000, 1'b1, 1'b0, 17'd1, 18'd1, 17'd1, 1'b0, 1'b1, 1'b0}},
        '{8'hFF, 1'b0, 1'b1,
          '{u8u16_pkg::REPLACEMENT, 1'b1, 1'b1, 17'd2, 18'd4, 17'd2, 1'b1, 1'b1, 1'b0}},
        '{8'h7F, 1'b1, 1'b1,
          '{16'h007F, 1'b1, 1'b0, 17'd3, 18'd5, 17'd3, 1'b1, 1'b1, 1'b1}},
        '{8'hC2, 1'b0, 1'b0, NO_WANT}, '{8'h80, 1'b0, 1'b0, NO_WANT},
        '{8'hE0, 1'b0, 1'b0, NO_WANT}, '{8'hA0, 1'b0, 1'b0, NO_WANT},
        '{8'h80, 1'b0, 1'b0, NO_WANT},
        '{8'hED, 1'b0, 1'b0, NO_WANT}, '{8'h9F, 1'b0, 1'b0, NO_WANT},
        '{8'hBF, 1'b0, 1'b0, NO_WANT},
        '{8'hED, 1'b0, 1'b0, NO_WANT}, '{8'hA0, 1'b0, 1'b0, NO_WANT},
        '{8'hF0, 1'b0, 1'b0, NO_WANT}, '{8'h90, 1'b0, 1'b0, NO_WANT},
        '{8'h80, 1'b0, 1'b0, NO_WANT}, '{8'h80, 1'b0, 1'b0, NO_WANT},
        '{8'hF4, 1'b0, 1'b0, NO_WANT}, '{8'h8F, 1'b0, 1'b0, NO_WANT},
        '{8'hBF, 1'b0, 1'b0, NO_WANT}, '{8'hBF, 1'b0, 1'b0, NO_WANT},
        '{8'hF4, 1'b0, 1'b0, NO_WANT}, '{8'h90, 1'b0, 1'b0, NO_WANT},
        '{8'hC1, 1'b0, 1'b0, NO_WANT},
        '{8'hE1, 1'b0, 1'b0, NO_WANT}, '{8'h80, 1'b1, 1'b0, NO_WANT},
        '{8'hF5, 1'b1, 1'b1,
          '{u8u16_pkg::REPLACEMENT, 1'b1, 1'b1, 17'd1, 18'd3, 17'd1, 1'b1, 1'b1, 1'b1}}
    };

    utf8_to_utf16_transcoder DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tlast  (s_last),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .o_m_axis_tlast  (m_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // A generous bound on the whole run.
    initial begin
        #40_000_000;
        $display("FAIL utf8_to_utf16_transcoder");
        $finish;
    end

    // ---------------------------------------------------------------
    // Decoder prediction
    // ---------------------------------------------------------------

    function automatic int unsigned capped_add(int unsigned v, int unsigned add,
                                               int unsigned cap);
        int unsigned s;
        s = v + add;
        return (s > cap) ? cap : s;
    endfunction

    // Forget the pending multi-byte sequence.
    task automatic clear_sequence();
        cp_acc     = '0;
        trails_due = '0;
        seq_len    = '0;
        trail_lo   = u8u16_pkg::TRAIL_LO_DEF;
        trail_hi   = u8u16_pkg::TRAIL_HI_DEF;
    endtask

    task automatic reset_decoder();
        clear_sequence();
        u8_sum   = 0;
        u16_sum  = 0;
        cp_sum   = 0;
        bad_seen = 1'b0;
    endtask

    // Add one unit to the totals and record it with the running offsets.
    task automatic push_unit(logic [15:0] unit, logic ends, logic repl, int unsigned add);
        u8u16_pkg::t_result r;
        u16_sum = capped_add(u16_sum, 1, 32'(u8u16_pkg::U16_CAP));
        if (ends) begin
            cp_sum = capped_add(cp_sum, 1, 32'(u8u16_pkg::CP_CAP));
            u8_sum = capped_add(u8_sum, add, 32'(u8u16_pkg::U8_CAP));
        end
        r.utf16_unit       = unit;
        r.ends_code_point  = ends;
        r.replaced         = repl;
        r.code_point_count = cp_sum[u8u16_pkg::CP_W-1:0];
        r.utf8_end         = u8_sum[u8u16_pkg::U8_W-1:0];
        r.utf16_end        = u16_sum[u8u16_pkg::U16_W-1:0];
        r.any_invalid      = bad_seen;
        r.run_last         = 1'b0;
        r.string_done      = 1'b0;
        step_units = {step_units, r};
    endtask

    task automatic push_replacement();
        bad_seen = 1'b1;
        push_unit(u8u16_pkg::REPLACEMENT, 1'b1, 1'b1, 3);
    endtask

    // Supplementary code points leave as a surrogate pair.
    task automatic push_code_point(logic [20:0] cp, int unsigned len);
        logic [20:0] v;
        if (cp >= u8u16_pkg::SUPP_MIN && cp <= u8u16_pkg::SUPP_MAX) begin
            v = cp - u8u16_pkg::SUPP_MIN;
            push_unit({u8u16_pkg::HIGH_SURR_TAG, v[19:10]}, 1'b0, 1'b0, 0);
            push_unit({u8u16_pkg::LOW_SURR_TAG, v[9:0]}, 1'b1, 1'b0, len);
        end else begin
            push_unit(cp[15:0], 1'b1, 1'b0, len);
        end
    endtask

    // Work out the results of one accepted byte into step_units.
    task automatic decode_byte(logic [7:0] b, logic eos);
        logic [2:0]         count;
        bit                 as_lead;
        bit                 started;
        u8u16_pkg::t_result tail;
        step_units.delete();
        as_lead = 1'b1;
        started = 1'b1;

        // A pending sequence either takes the byte as a trail or is replaced.
        if (trails_due != 0) begin
            if (b >= trail_lo && b <= trail_hi) begin
                count      = {1'b0, seq_len} + 3'd1;
                as_lead    = 1'b0;
                cp_acc     = {cp_acc[14:0], b[5:0]};
                trails_due = trails_due - 2'd1;
                trail_lo   = u8u16_pkg::TRAIL_LO_DEF;
                trail_hi   = u8u16_pkg::TRAIL_HI_DEF;
                if (trails_due == 0) begin
                    push_code_point(cp_acc, 32'(count));
                    clear_sequence();
                end else begin
                    seq_len = count[1:0];
                    if (eos) begin
                        push_replacement();
                        clear_sequence();
                    end
                end
            end else begin
                push_replacement();
                clear_sequence();
            end
        end

        // Lead byte: ASCII, start of a sequence, or an ill-formed lead.
        if (as_lead) begin
            if (b < 8'h80) begin
                push_unit({8'h00, b}, 1'b1, 1'b0, 1);
                started = 1'b0;
            end else if (b >= u8u16_pkg::LEAD2_MIN && b <= u8u16_pkg::LEAD2_MAX) begin
                trails_due = 2'd1;
                cp_acc     = {16'd0, b[4:0]};
            end else if (b >= u8u16_pkg::LEAD3_MIN && b <= u8u16_pkg::LEAD3_MAX) begin
                trails_due = 2'd2;
                cp_acc     = {17'd0, b[3:0]};
                if (b == u8u16_pkg::LEAD_E0)
                    trail_lo = u8u16_pkg::TRAIL_LO_E0;
                else if (b == u8u16_pkg::LEAD_ED)
                    trail_hi = u8u16_pkg::TRAIL_HI_ED;
            end else if (b >= u8u16_pkg::LEAD4_MIN && b <= u8u16_pkg::LEAD4_MAX) begin
                trails_due = 2'd3;
                cp_acc     = {18'd0, b[2:0]};
                if (b == u8u16_pkg::LEAD_F0)
                    trail_lo = u8u16_pkg::TRAIL_LO_F0;
                else if (b == u8u16_pkg::LEAD_F4)
                    trail_hi = u8u16_pkg::TRAIL_HI_F4;
            end else begin
                push_replacement();
                started = 1'b0;
            end
            if (started) begin
                seq_len = 2'd1;
                if (eos) begin
                    push_replacement();
                    clear_sequence();
                end
            end
        end

        // Mark the last unit of this byte, and of the string.
        if (step_units.size() > 0) begin
            tail = step_units.pop_back();
            tail.run_last = 1'b1;
            if (eos)
                tail.string_done = 1'b1;
            step_units = {step_units, tail};
        end
        if (eos)
            reset_decoder();
    endtask

    // ---------------------------------------------------------------
    // Request prediction and result checking, both sampled at the rising edge
    // ---------------------------------------------------------------

    task automatic show_result(string tag, u8u16_pkg::t_result r);
        $display("  %s unit=%h ends=%b repl=%b cps=%0d u8=%0d u16=%0d",
                 tag, r.utf16_unit, r.ends_code_point, r.replaced,
                 r.code_point_count, r.utf8_end, r.utf16_end);
        $display("       inv=%b run_last=%b done=%b",
                 r.any_invalid, r.run_last, r.string_done);
    endtask

    always @(posedge i_clk) begin
        u8u16_pkg::t_result got;
        u8u16_pkg::t_result want;
        if (i_rst_n) begin
            if (s_valid && s_ready) begin
                decode_byte(s_data, s_last);
                if (row_typed)
                    units_due = {units_due, row_want};
                else
                    foreach (step_units[k])
                        units_due = {units_due, step_units[k]};
            end

            if (m_valid && m_ready) begin
                got.utf16_unit       = m_data[15:0];
                got.code_point_count = m_data[32:16];
                got.utf8_end         = m_data[50:33];
                got.utf16_end        = m_data[67:51];
                got.any_invalid      = m_data[68];
                got.run_last         = m_data[69];
                got.ends_code_point  = m_user[0];
                got.replaced         = m_user[1];
                got.string_done      = m_last;
                if (units_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("unexpected result at %0t", $realtime);
                        show_result("got ", got);
                    end
                end else begin
                    want = units_due.pop_front();
                    if (got !== want || m_data[71:70] !== 2'b00) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("result mismatch at %0t (pad bits %b)", $realtime,
                                     m_data[71:70]);
                            show_result("want", want);
                            show_result("got ", got);
                        end
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Result receiver: stalls on its own pattern, plus one long hold-off
    // ---------------------------------------------------------------

    initial begin
        int  stall_left;
        int  mode_left;
        int  hold_left;
        bit  stall_mode;
        bit  hold_taken;
        m_ready    = 1'b0;
        stall_left = 0;
        mode_left  = 0;
        hold_left  = 0;
        stall_mode = 1'b0;
        hold_taken = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_pending && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                // Alternate between stretches of steady accept and stretches with stalls.
                if (mode_left == 0) begin
                    mode_left  = $urandom_range(16, 96);
                    stall_mode = ($urandom_range(0, 2) != 0);
                end
                mode_left--;
                if (stall_left > 0) begin
                    stall_left--;
                    m_ready <= 1'b0;
                end else if (stall_mode && $urandom_range(0, 3) == 0) begin
                    stall_left = $urandom_range(0, 2);
                    m_ready <= 1'b0;
                end else begin
                    m_ready <= 1'b1;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Byte sender and string builders
    // ---------------------------------------------------------------

    // Offer one byte, with random gaps between bursts, and wait for the request to go through.
    task automatic send_byte(logic [7:0] b, logic eos, logic typed, u8u16_pkg::t_result want);
        int gap;
        if (steady_left > 0) begin
            steady_left--;
        end else if (burst_left == 0) begin
            gap = $urandom_range(1, 4);
            repeat (gap) begin
                @(negedge i_clk);
                s_valid <= 1'b0;
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(64, 200)
                                                     : $urandom_range(1, 32);
        end
        if (burst_left > 0)
            burst_left--;
        @(negedge i_clk);
        s_valid   <= 1'b1;
        s_data    <= b;
        s_last    <= eos;
        row_typed <= typed;
        row_want  <= want;
        items_sent++;
        do @(posedge i_clk); while (!s_ready);
    endtask

    task automatic send_string();
        for (int i = 0; i < str_bytes.size(); i++)
            send_byte(str_bytes[i], (i == str_bytes.size() - 1), 1'b0, NO_WANT);
        str_bytes.delete();
    endtask

    task automatic add_trail(logic [7:0] lo, logic [7:0] hi);
        str_bytes = {str_bytes, 8'($urandom_range(lo, hi))};
    endtask

    // One well-formed character with random content; the tight-range leads come often.
    task automatic add_well_formed();
        int         kind;
        logic [7:0] lead;
        kind = $urandom_range(0, 9);
        if (kind < 4) begin
            str_bytes = {str_bytes, 8'($urandom_range(0, 127))};
        end else if (kind < 6) begin
            str_bytes = {str_bytes,
                         8'($urandom_range(u8u16_pkg::LEAD2_MIN, u8u16_pkg::LEAD2_MAX))};
            add_trail(u8u16_pkg::TRAIL_LO_DEF, u8u16_pkg::TRAIL_HI_DEF);
        end else if (kind < 8) begin
            case ($urandom_range(0, 3))
                0: lead = u8u16_pkg::LEAD_E0;
                1: lead = u8u16_pkg::LEAD_ED;
                default: lead = 8'($urandom_range(u8u16_pkg::LEAD3_MIN, u8u16_pkg::LEAD3_MAX));
            endcase
            str_bytes = {str_bytes, lead};
            if (lead == u8u16_pkg::LEAD_E0)
                add_trail(u8u16_pkg::TRAIL_LO_E0, u8u16_pkg::TRAIL_HI_DEF);
            else if (lead == u8u16_pkg::LEAD_ED)
                add_trail(u8u16_pkg::TRAIL_LO_DEF, u8u16_pkg::TRAIL_HI_ED);
            else
                add_trail(u8u16_pkg::TRAIL_LO_DEF, u8u16_pkg::TRAIL_HI_DEF);
            add_trail(u8u16_pkg::TRAIL_LO_DEF, u8u16_pkg::TRAIL_HI_DEF);
        end else begin
            case ($urandom_range(0, 3))
                0: lead = u8u16_pkg::LEAD_F0;
                1: lead = u8u16_pkg::LEAD_F4;
                default: lead = 8'($urandom_range(u8u16_pkg::LEAD4_MIN, u8u16_pkg::LEAD4_MAX));
            endcase
            str_bytes = {str_bytes, lead};
            if (lead == u8u16_pkg::LEAD_F0)
                add_trail(u8u16_pkg::TRAIL_LO_F0, u8u16_pkg::TRAIL_HI_DEF);
            else if (lead == u8u16_pkg::LEAD_F4)
                add_trail(u8u16_pkg::TRAIL_LO_DEF, u8u16_pkg::TRAIL_HI_F4);
            else
                add_trail(u8u16_pkg::TRAIL_LO_DEF, u8u16_pkg::TRAIL_HI_DEF);
            add_trail(u8u16_pkg::TRAIL_LO_DEF, u8u16_pkg::TRAIL_HI_DEF);
            add_trail(u8u16_pkg::TRAIL_LO_DEF, u8u16_pkg::TRAIL_HI_DEF);
        end
    endtask

    // Noise: a random byte, a cut-short sequence, or a lead with an arbitrary second byte.
    task automatic add_noise();
        int start;
        int drop;
        case ($urandom_range(0, 2))
            0: str_bytes = {str_bytes, 8'($urandom_range(0, 255))};
            1: begin
                start = str_bytes.size();
                add_well_formed();
                if (str_bytes.size() - start > 1) begin
                    drop = $urandom_range(1, str_bytes.size() - start - 1);
                    repeat (drop) void'(str_bytes.pop_back());
                end
            end
            default: begin
                str_bytes = {str_bytes,
                             8'($urandom_range(u8u16_pkg::LEAD2_MIN, u8u16_pkg::LEAD4_MAX))};
                str_bytes = {str_bytes, 8'($urandom_range(0, 255))};
            end
        endcase
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------

    initial begin
        int n_chars;
        s_valid      = 1'b0;
        s_data       = '0;
        s_last       = 1'b0;
        row_typed    = 1'b0;
        row_want     = NO_WANT;
        i_rst_n      = 1'b0;
        fail_count   = 0;
        items_sent   = 0;
        burst_left   = 0;
        steady_left  = 0;
        hold_pending = 1'b0;
        reset_decoder();

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table: extremes, tight second-byte ranges, bad leads and trails, truncation.
        for (int k = 0; k < DIR_ROWS; k++)
            send_byte(dir_table[k].byte_value, dir_table[k].eos, dir_table[k].typed,
                      dir_table[k].want);

        // Long receiver hold-off while the sender keeps offering back to back.
        hold_pending = 1'b1;
        steady_left  = 80;

        // Random strings, mostly well formed, some noise.
        while (items_sent < DIR_ROWS + RANDOM_ITEMS) begin
            n_chars = $urandom_range(1, 12);
            repeat (n_chars) begin
                if ($urandom_range(0, 19) < 3)
                    add_noise();
                else
                    add_well_formed();
            end
            send_string();
        end

        @(negedge i_clk);
        s_valid <= 1'b0;

        while (units_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("PASS utf8_to_utf16_transcoder");
        else
            $display("FAIL utf8_to_utf16_transcoder");
        $finish;
    end

endmodule
